FILE: rtl/core/lpbg_pkg.sv
`timescale 1ns / 1ps

package lpbg_pkg;

    // Store geometry.
    localparam int MAX_PIXELS = 64;
    localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int SUM_W      = LEN_W + 1;
    localparam int PIX_W      = 24;
    localparam int COLOR_W    = 32;
    localparam int SLOT_W     = 3;
    localparam int GAMMA_BITS = 256 * 8;

    // Command codes of an input transaction.
    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_MAX  = 2'd1,
        OP_FILL = 2'd2,
        OP_SHOW = 2'd3
    } op_t;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_STRIP_LENGTH = 3'd0,
        REG_BRIGHTNESS   = 3'd1,
        REG_SLOT_FIRST   = 3'd2,
        REG_SLOT_SECOND  = 3'd3,
        REG_SLOT_THIRD   = 3'd4
    } reg_idx_t;

    // Color codes held by the slot registers.
    typedef enum logic [2:0] {
        SLOT_NONE  = 3'd0,
        SLOT_RED   = 3'd1,
        SLOT_GREEN = 3'd2,
        SLOT_BLUE  = 3'd3,
        SLOT_WHITE = 3'd4
    } slot_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAX_WR,
        S_FILL,
        S_SHOW_RD,
        S_SHOW_MUL,
        S_SHOW_OUT
    } state_t;

    typedef enum logic [1:0] {
        WR_INPUT,
        WR_MAX,
        WR_FILL
    } wr_sel_t;

    typedef enum logic {
        RD_INPUT,
        RD_ADDR
    } rd_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    load_show;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    addr_inc;
        logic    scale_en;
        logic    out_load;
    } lpbg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_in_range;
        logic len_zero;
        logic fill_more;
        logic last;
        logic out_free;
    } lpbg_status_t;

    // Gamma ROM, round(255*(i/255)^1.7), built at elaboration.
    function automatic logic [GAMMA_BITS-1:0] build_gamma_rom();
        logic [GAMMA_BITS-1:0] tbl;
        real                   x;
        int                    k;
        tbl = '0;
        for (k = 0; k < 256; k++)
        begin
            x = 255.0 * ((k / 255.0) ** 1.7);
            tbl[k*8 +: 8] = 8'($rtoi(x + 0.5));
        end
        tbl[255*8 +: 8] = 8'd255;
        return tbl;
    endfunction

    localparam logic [GAMMA_BITS-1:0] GAMMA_ROM = build_gamma_rom();

    function automatic logic [7:0] gamma_lookup(input logic [7:0] v);
        return GAMMA_ROM[{v, 3'b000} +: 8];
    endfunction

    // Select one color byte for a wire slot.
    function automatic logic [7:0] pick_byte(input logic [SLOT_W-1:0] code,
                                             input logic [COLOR_W-1:0] color);
        logic [7:0] b;
        unique case (code)
            SLOT_RED:   b = color[7:0];
            SLOT_GREEN: b = color[15:8];
            SLOT_BLUE:  b = color[23:16];
            SLOT_WHITE: b = color[31:24];
            default:    b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/lpbg_ram.sv
`timescale 1ns / 1ps

module lpbg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/lpbg_ctrl.sv
`timescale 1ns / 1ps

module lpbg_ctrl
    import lpbg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   opcode,
    input  lpbg_status_t status,
    output lpbg_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;
    op_t    op;

    assign op     = op_t'(opcode);
    assign accept = in_valid && (state_reg == S_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_SET:  state_next = S_IDLE;
                        OP_MAX:  state_next = status.idx_in_range ? S_MAX_WR : S_IDLE;
                        OP_FILL: state_next = S_FILL;
                        OP_SHOW: state_next = status.len_zero ? S_IDLE : S_SHOW_RD;
                    endcase
                end
            end
            S_MAX_WR:   state_next = S_IDLE;
            S_FILL:     state_next = status.fill_more ? S_FILL : S_IDLE;
            S_SHOW_RD:  state_next = S_SHOW_MUL;
            S_SHOW_MUL: state_next = S_SHOW_OUT;
            S_SHOW_OUT:
            begin
                if (status.out_free)
                begin
                    state_next = status.last ? S_IDLE : S_SHOW_RD;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.wr_sel    = WR_INPUT;
        cmd.rd_sel    = RD_INPUT;
        in_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load      = accept;
                cmd.load_show = accept && (op == OP_SHOW);
                cmd.wr_en     = accept && (op == OP_SET) && status.idx_in_range;
                cmd.rd_en     = accept && (op == OP_MAX);
            end
            S_MAX_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_MAX;
            end
            S_FILL:
            begin
                cmd.wr_en    = status.fill_more;
                cmd.wr_sel   = WR_FILL;
                cmd.addr_inc = status.fill_more;
            end
            S_SHOW_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_ADDR;
            end
            S_SHOW_MUL:
            begin
                cmd.scale_en = 1'b1;
                cmd.addr_inc = 1'b1;
            end
            S_SHOW_OUT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A show run with an empty strip must never start reading the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && state_next == S_SHOW_RD) |-> !status.len_zero)
        else $error("show run started on an empty strip");

    // A pixel is handed to the output register only when that register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten while occupied");
`endif

endmodule

FILE: rtl/core/lpbg_dp.sv
`timescale 1ns / 1ps

module lpbg_dp
    import lpbg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lpbg_cmd_t          cmd,
    output lpbg_status_t       status,
    input  logic [IDX_W-1:0]   index,
    input  logic [CNT_W-1:0]   count,
    input  logic [COLOR_W-1:0] color,
    input  logic [LEN_W-1:0]   strip_length,
    input  logic [7:0]         brightness,
    input  logic [SLOT_W-1:0]  slot_first,
    input  logic [SLOT_W-1:0]  slot_second,
    input  logic [SLOT_W-1:0]  slot_third,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        pixel_word,
    output logic               last_pixel
);

    logic [LEN_W-1:0]  len;
    logic [PIX_W-1:0]  in_slots;
    logic [SUM_W-1:0]  fill_sum;
    logic [LEN_W-1:0]  fill_end;

    logic [PIX_W-1:0]  pix_reg;
    logic [LEN_W-1:0]  addr_reg;
    logic [LEN_W-1:0]  end_reg;
    logic              last_reg;
    logic [23:0]       scaled_reg;

    logic              out_valid_reg;
    logic [31:0]       pixel_word_reg;
    logic              last_pixel_reg;

    logic [LEN_W-1:0]  wr_addr_full;
    logic [PIX_W-1:0]  wr_data;
    logic [PIX_W-1:0]  max_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]  ram_rdata;
    logic [15:0]       prod0;
    logic [15:0]       prod1;
    logic [15:0]       prod2;

    // Effective strip length, limited to the store size.
    assign len = (strip_length > LEN_W'(MAX_PIXELS)) ? LEN_W'(MAX_PIXELS) : strip_length;

    // Reorder the incoming color into the three wire slots.
    assign in_slots = {pick_byte(slot_first, color),
                       pick_byte(slot_second, color),
                       pick_byte(slot_third, color)};

    // End of a fill range, clamped at the strip end.
    assign fill_sum = SUM_W'(index) + SUM_W'(count);
    assign fill_end = (fill_sum > SUM_W'(len)) ? len : fill_sum[LEN_W-1:0];

    // Command latch and walking address.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg  <= in_slots;
            addr_reg <= cmd.load_show ? '0 : LEN_W'(index);
            end_reg  <= cmd.load_show ? len : fill_end;
        end
        else if (cmd.addr_inc)
        begin
            addr_reg <= addr_reg + LEN_W'(1);
        end
    end

    // Per-byte maximum of the stored and the new pixel.
    always_comb
    begin
        for (int b = 0; b < 3; b++)
        begin
            max_data[b*8 +: 8] = (pix_reg[b*8 +: 8] > ram_rdata[b*8 +: 8]) ?
                                 pix_reg[b*8 +: 8] : ram_rdata[b*8 +: 8];
        end
    end

    // Store write port selection.
    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_INPUT:
            begin
                wr_addr_full = LEN_W'(index);
                wr_data      = in_slots;
            end
            WR_MAX:
            begin
                wr_addr_full = addr_reg;
                wr_data      = max_data;
            end
            WR_FILL:
            begin
                wr_addr_full = addr_reg;
                wr_data      = pix_reg;
            end
            default:
            begin
                wr_addr_full = addr_reg;
                wr_data      = pix_reg;
            end
        endcase
    end

    assign rd_addr = (cmd.rd_sel == RD_ADDR) ? addr_reg[ADDR_W-1:0] : index[ADDR_W-1:0];

    lpbg_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_addr_full[ADDR_W-1:0]),
        .wdata (wr_data),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Brightness scaling, one product per slot byte.
    assign prod0 = ram_rdata[23:16] * brightness;
    assign prod1 = ram_rdata[15:8]  * brightness;
    assign prod2 = ram_rdata[7:0]   * brightness;

    always_ff @(posedge clk)
    begin
        if (cmd.scale_en)
        begin
            scaled_reg <= {prod0[15:8], prod1[15:8], prod2[15:8]};
            last_reg   <= (addr_reg + LEN_W'(1)) == end_reg;
        end
    end

    // Output register: valid flag under reset, payload without.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            pixel_word_reg <= {gamma_lookup(scaled_reg[23:16]),
                               gamma_lookup(scaled_reg[15:8]),
                               gamma_lookup(scaled_reg[7:0]),
                               8'd0};
            last_pixel_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_word = pixel_word_reg;
    assign last_pixel = last_pixel_reg;

    // Status back to the controller.
    assign status.idx_in_range = LEN_W'(index) < len;
    assign status.len_zero     = (len == '0);
    assign status.fill_more    = addr_reg < end_reg;
    assign status.last         = last_reg;
    assign status.out_free     = !out_valid_reg || out_ready;

`ifndef ASSERT_OFF
    // Every store write lands inside the strip.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (wr_addr_full < len))
        else $error("store write beyond strip length");

    // A show read never runs past the end of the strip.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en && cmd.rd_sel == RD_ADDR) |-> (addr_reg < end_reg))
        else $error("show read past the last pixel");
`endif

endmodule

FILE: rtl/core/led_pixel_buffer_gamma.sv
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// input     in_valid / in_ready        opcode, index, count, color
// output    out_valid / out_ready      pixel_word, last_pixel
// config    psel, penable, pwrite      paddr, pwdata, prdata, pready (always high)
//
// Set writes the store as it is taken; max reads the stored pixel, then writes back the per-byte
// maximum with the new color; fill writes the pixels of its range one after another. Show walks
// each pixel through store read, brightness multiply and gamma lookup, and waits in the last step
// while the output register is occupied; the controller walks one pixel at a time. A new
// transaction is taken once the last pixel sits in the output register. Reset restores the
// register defaults; the pixel store holds nothing until written.

module led_pixel_buffer_gamma
    import lpbg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [IDX_W-1:0]   index,
    input  logic [CNT_W-1:0]   count,
    input  logic [COLOR_W-1:0] color,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        pixel_word,
    output logic               last_pixel,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [LEN_W-1:0]  strip_length_reg;
    logic [7:0]        brightness_reg;
    logic [SLOT_W-1:0] slot_first_reg;
    logic [SLOT_W-1:0] slot_second_reg;
    logic [SLOT_W-1:0] slot_third_reg;
    logic              cfg_write;
    reg_idx_t          reg_sel;
    lpbg_cmd_t         cmd;
    lpbg_status_t      status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = reg_idx_t'(paddr[4:2]);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_length_reg <= LEN_W'(64);
            brightness_reg   <= 8'd255;
            slot_first_reg   <= SLOT_GREEN;
            slot_second_reg  <= SLOT_RED;
            slot_third_reg   <= SLOT_BLUE;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_STRIP_LENGTH: strip_length_reg <= pwdata[LEN_W-1:0];
                REG_BRIGHTNESS:   brightness_reg   <= pwdata[7:0];
                REG_SLOT_FIRST:   slot_first_reg   <= pwdata[SLOT_W-1:0];
                REG_SLOT_SECOND:  slot_second_reg  <= pwdata[SLOT_W-1:0];
                REG_SLOT_THIRD:   slot_third_reg   <= pwdata[SLOT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_sel)
            REG_STRIP_LENGTH: prdata = 32'(strip_length_reg);
            REG_BRIGHTNESS:   prdata = 32'(brightness_reg);
            REG_SLOT_FIRST:   prdata = 32'(slot_first_reg);
            REG_SLOT_SECOND:  prdata = 32'(slot_second_reg);
            REG_SLOT_THIRD:   prdata = 32'(slot_third_reg);
            default:          prdata = 32'd0;
        endcase
    end

    lpbg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .status   (status),
        .cmd      (cmd)
    );

    lpbg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .index        (index),
        .count        (count),
        .color        (color),
        .strip_length (strip_length_reg),
        .brightness   (brightness_reg),
        .slot_first   (slot_first_reg),
        .slot_second  (slot_second_reg),
        .slot_third   (slot_third_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_word   (pixel_word),
        .last_pixel   (last_pixel)
    );

endmodule
